// File: design/love_hate_frame_replacement_assert.svh
// Assertion macros for the love/hate frame replacement block.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef LOVE_HATE_FRAME_REPLACEMENT_ASSERT_SVH
`define LOVE_HATE_FRAME_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LHFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LHFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lhfr_pkg.sv
// Shared types, codes and the control store of the love/hate frame replacement block.
// No dependencies; used by the channel interfaces and the top level.
package lhfr_pkg;

  localparam int FRAME_W = 6;
  localparam int FRAME_SPAN = 1 << FRAME_W;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_LISTED = 2'd2;

  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_HATE = 2'd1;
  localparam logic [1:0] MEM_LOVE = 2'd2;

  typedef enum logic [1:0] {RD_NONE, RD_F, RD_H} rd_sel_t;
  typedef enum logic [2:0] {WR_NONE, WR_SELF, WR_NODE, WR_NEIGH, WR_UNLINK} wr_op_t;
  typedef enum logic [1:0] {MO_NONE, MO_SET, MO_CLR} mem_op_t;
  typedef enum logic [1:0] {HO_KEEP, HO_SET, HO_UNLINK} head_op_t;
  typedef enum logic [2:0] {LD_NONE, LD_T, LD_NP, LD_F_RD, LD_F_HATE, LD_LOVE} ld_op_t;
  typedef enum logic [2:0] {
    CC_NEVER, CC_ALWAYS, CC_LISTED, CC_NOTMEM, CC_EMPTY, CC_HATE_EMPTY, CC_LOVE_EMPTY
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    rd_sel_t    rd;
    wr_op_t     wr;
    mem_op_t    mo;
    head_op_t   ho;
    ld_op_t     ld;
    cond_t      cc;
    upc_t       target;
    logic       fin;
    logic [1:0] status;
    logic       victim;
  } ctrl_t;

  // Step addresses
  localparam upc_t S_I_RD       = 5'd0;
  localparam upc_t S_I_CHK      = 5'd1;
  localparam upc_t S_I_HEAD     = 5'd2;
  localparam upc_t S_I_TAIL     = 5'd3;
  localparam upc_t S_I_NODE     = 5'd4;
  localparam upc_t S_I_NEIGH    = 5'd5;
  localparam upc_t S_I_SELF     = 5'd6;
  localparam upc_t S_R_RD       = 5'd7;
  localparam upc_t S_R_CHK      = 5'd8;
  localparam upc_t S_R_UNL      = 5'd9;
  localparam upc_t S_L_HATE     = 5'd10;
  localparam upc_t S_L_PICKH    = 5'd11;
  localparam upc_t S_L_LOVE     = 5'd12;
  localparam upc_t S_L_TAILRD   = 5'd13;
  localparam upc_t S_L_TAIL     = 5'd14;
  localparam upc_t S_V_RD       = 5'd15;
  localparam upc_t S_V_NP       = 5'd16;
  localparam upc_t S_V_UNL      = 5'd17;
  localparam upc_t S_FIN_OK     = 5'd18;
  localparam upc_t S_FIN_ABSENT = 5'd19;
  localparam upc_t S_FIN_LISTED = 5'd20;
  localparam upc_t S_FIN_VICTIM = 5'd21;

  localparam ctrl_t CW_NOP = '{
    rd: RD_NONE, wr: WR_NONE, mo: MO_NONE, ho: HO_KEEP, ld: LD_NONE,
    cc: CC_NEVER, target: 5'd0, fin: 1'b0, status: ST_OK, victim: 1'b0
  };

  function automatic ctrl_t ucode(upc_t a);
    ctrl_t w;
    w = CW_NOP;
    case (a)
      S_I_RD:     w.rd = RD_F;
      S_I_CHK: begin
        w.cc = CC_LISTED; w.target = S_FIN_LISTED;
      end
      S_I_HEAD: begin
        w.rd = RD_H; w.cc = CC_EMPTY; w.target = S_I_SELF;
      end
      S_I_TAIL:   w.ld = LD_T;
      S_I_NODE: begin
        w.wr = WR_NODE; w.mo = MO_SET;
      end
      S_I_NEIGH: begin
        w.wr = WR_NEIGH; w.ho = HO_SET; w.cc = CC_ALWAYS; w.target = S_FIN_OK;
      end
      S_I_SELF: begin
        w.wr = WR_SELF; w.mo = MO_SET; w.ho = HO_SET;
        w.cc = CC_ALWAYS; w.target = S_FIN_OK;
      end
      S_R_RD:     w.rd = RD_F;
      S_R_CHK: begin
        w.ld = LD_NP; w.cc = CC_NOTMEM; w.target = S_FIN_ABSENT;
      end
      S_R_UNL: begin
        w.wr = WR_UNLINK; w.mo = MO_CLR; w.ho = HO_UNLINK;
        w.cc = CC_ALWAYS; w.target = S_FIN_OK;
      end
      S_L_HATE: begin
        w.cc = CC_HATE_EMPTY; w.target = S_L_LOVE;
      end
      S_L_PICKH: begin
        w.ld = LD_F_HATE; w.cc = CC_ALWAYS; w.target = S_V_RD;
      end
      S_L_LOVE: begin
        w.ld = LD_LOVE; w.cc = CC_LOVE_EMPTY; w.target = S_FIN_ABSENT;
      end
      S_L_TAILRD: w.rd = RD_H;
      S_L_TAIL:   w.ld = LD_F_RD;
      S_V_RD:     w.rd = RD_F;
      S_V_NP:     w.ld = LD_NP;
      S_V_UNL: begin
        w.wr = WR_UNLINK; w.mo = MO_CLR; w.ho = HO_UNLINK;
        w.cc = CC_ALWAYS; w.target = S_FIN_VICTIM;
      end
      S_FIN_OK: begin
        w.fin = 1'b1; w.status = ST_OK;
      end
      S_FIN_LISTED: begin
        w.fin = 1'b1; w.status = ST_LISTED;
      end
      S_FIN_VICTIM: begin
        w.fin = 1'b1; w.status = ST_OK; w.victim = 1'b1;
      end
      default: begin
        w.fin = 1'b1; w.status = ST_ABSENT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/lhfr_if.sv
// Request and response channel interfaces of the love/hate frame replacement block.
// Depends on lhfr_pkg for the frame field width.
interface lhfr_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic                       list_sel;
  logic [lhfr_pkg::FRAME_W-1:0] frame_no;

  modport source(output valid, func, list_sel, frame_no, input ready);
  modport sink(input valid, func, list_sel, frame_no, output ready);
endinterface

interface lhfr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [lhfr_pkg::FRAME_W-1:0] victim_frame;

  modport source(output valid, status, victim_frame, input ready);
  modport sink(input valid, status, victim_frame, output ready);
endinterface

// File: design/lhfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the link and membership stores.
module lhfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/love_hate_frame_replacement.sv
// Love/hate frame replacement lists: top level with the control sequencer and datapath.
// Depends on lhfr_pkg, lhfr_if.sv, lhfr_ram.sv and love_hate_frame_replacement_assert.svh.

// Keeps a hate list and a love list of buffer frames as doubly linked circular
// lists in RAM. One request is worked at a time by a small control program; the
// next request is taken in the cycle after the result is written to the output
// register, which holds it until the sink takes it. A frame beyond the pool or an
// unused code goes straight to the result; rejected inserts and removes and lookups
// on empty lists are shorter than the rest, and a lookup from the love list is the
// longest. The length is set by the registered reads of the link RAMs and their
// single write port, which puts each dependent read and each pair of link writes
// in a step of its own. Only frames below both NUM_FRAMES and 64 can be listed, so
// the stores are sized to the smaller of the two.
module love_hate_frame_replacement #(
  parameter int NUM_FRAMES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  lhfr_req_if.sink       in_req,
  lhfr_rsp_if.source     out_rsp
);

  localparam int DEPTH = (NUM_FRAMES < lhfr_pkg::FRAME_SPAN) ? NUM_FRAMES
                                                             : lhfr_pkg::FRAME_SPAN;
  localparam int AW = $clog2(DEPTH);

  typedef logic [AW-1:0] fidx_t;

  // Sequencer and datapath registers
  logic              busy_r, busy_nxt;
  lhfr_pkg::upc_t    upc_r, upc_nxt;
  logic              lsel_r, lsel_nxt;
  fidx_t             f_r, f_nxt;
  fidx_t             t_r, t_nxt;
  fidx_t             n_r, n_nxt;
  fidx_t             p_r, p_nxt;
  fidx_t             hate_head_r, hate_head_nxt;
  fidx_t             love_head_r, love_head_nxt;
  logic              hate_empty_r, hate_empty_nxt;
  logic              love_empty_r, love_empty_nxt;
  logic [DEPTH-1:0]  vld_r, vld_nxt;
  logic              vld_q_r;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [lhfr_pkg::FRAME_W-1:0] out_victim_r, out_victim_nxt;

  lhfr_pkg::ctrl_t   ctl;
  logic              in_fire;
  logic              in_range;
  lhfr_pkg::upc_t    entry;
  logic              fin_stall;
  logic              exec;
  logic              cond_true;
  fidx_t             head_sel;
  logic              empty_sel;
  logic [1:0]        lsel_code;
  logic [1:0]        mem_cur;

  fidx_t             raddr;
  fidx_t             next_rd, prev_rd;
  logic [1:0]        mem_rd;
  logic              next_we, prev_we, mem_we;
  fidx_t             next_waddr, prev_waddr;
  fidx_t             next_wdata, prev_wdata;
  logic [1:0]        mem_wdata;

  assign ctl       = lhfr_pkg::ucode(upc_r);
  assign head_sel  = lsel_r ? love_head_r : hate_head_r;
  assign empty_sel = lsel_r ? love_empty_r : hate_empty_r;
  assign lsel_code = lsel_r ? lhfr_pkg::MEM_LOVE : lhfr_pkg::MEM_HATE;
  assign mem_cur   = vld_q_r ? mem_rd : lhfr_pkg::MEM_NONE;

  assign fin_stall = ctl.fin && out_valid_r && !out_rsp.ready;
  assign exec      = busy_r && !fin_stall;

  assign in_req.ready = !busy_r;
  assign in_fire      = in_req.valid && in_req.ready;
  assign in_range     = int'(in_req.frame_no) < NUM_FRAMES;

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.victim_frame = out_victim_r;

  always_comb begin
    case (in_req.func)
      lhfr_pkg::FN_INSERT: entry = in_range ? lhfr_pkg::S_I_RD : lhfr_pkg::S_FIN_ABSENT;
      lhfr_pkg::FN_REMOVE: entry = in_range ? lhfr_pkg::S_R_RD : lhfr_pkg::S_FIN_ABSENT;
      lhfr_pkg::FN_LOOKUP: entry = lhfr_pkg::S_L_HATE;
      default:             entry = lhfr_pkg::S_FIN_ABSENT;
    endcase
  end

  always_comb begin
    case (ctl.cc)
      lhfr_pkg::CC_ALWAYS:     cond_true = 1'b1;
      lhfr_pkg::CC_LISTED:     cond_true = mem_cur != lhfr_pkg::MEM_NONE;
      lhfr_pkg::CC_NOTMEM:     cond_true = mem_cur != lsel_code;
      lhfr_pkg::CC_EMPTY:      cond_true = empty_sel;
      lhfr_pkg::CC_HATE_EMPTY: cond_true = hate_empty_r;
      lhfr_pkg::CC_LOVE_EMPTY: cond_true = love_empty_r;
      default:                 cond_true = 1'b0;
    endcase
  end

  // The stores are read every cycle; data belongs to the previous step's address
  always_comb begin
    case (ctl.rd)
      lhfr_pkg::RD_H: raddr = head_sel;
      default:        raddr = f_r;
    endcase
  end

  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = f_r;
    prev_waddr = f_r;
    next_wdata = f_r;
    prev_wdata = f_r;
    if (exec) begin
      case (ctl.wr)
        lhfr_pkg::WR_SELF: begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
        lhfr_pkg::WR_NODE: begin
          next_we    = 1'b1;
          prev_we    = 1'b1;
          next_wdata = head_sel;
          prev_wdata = t_r;
        end
        lhfr_pkg::WR_NEIGH: begin
          // link the old tail and the old head to the new frame
          next_we    = 1'b1;
          prev_we    = 1'b1;
          next_waddr = t_r;
          prev_waddr = head_sel;
        end
        lhfr_pkg::WR_UNLINK: begin
          next_we    = 1'b1;
          prev_we    = 1'b1;
          next_waddr = p_r;
          next_wdata = n_r;
          prev_waddr = n_r;
          prev_wdata = p_r;
        end
        default: begin
          next_we = 1'b0;
          prev_we = 1'b0;
        end
      endcase
    end
  end

  assign mem_we    = exec && (ctl.mo != lhfr_pkg::MO_NONE);
  assign mem_wdata = (ctl.mo == lhfr_pkg::MO_SET) ? lsel_code : lhfr_pkg::MEM_NONE;

  always_comb begin
    busy_nxt       = busy_r;
    upc_nxt        = upc_r;
    lsel_nxt       = lsel_r;
    f_nxt          = f_r;
    t_nxt          = t_r;
    n_nxt          = n_r;
    p_nxt          = p_r;
    hate_head_nxt  = hate_head_r;
    love_head_nxt  = love_head_r;
    hate_empty_nxt = hate_empty_r;
    love_empty_nxt = love_empty_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_victim_nxt = out_victim_r;

    if (in_fire) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry;
      lsel_nxt = in_req.list_sel;
      if (in_range) begin
        f_nxt = AW'(in_req.frame_no);
      end
    end

    if (exec) begin
      case (ctl.ld)
        lhfr_pkg::LD_T:  t_nxt = prev_rd;
        lhfr_pkg::LD_NP: begin
          n_nxt = next_rd;
          p_nxt = prev_rd;
        end
        lhfr_pkg::LD_F_RD: f_nxt = prev_rd;
        lhfr_pkg::LD_F_HATE: begin
          f_nxt    = hate_head_r;
          lsel_nxt = 1'b0;
        end
        lhfr_pkg::LD_LOVE: lsel_nxt = 1'b1;
        default: t_nxt = t_r;
      endcase

      case (ctl.ho)
        lhfr_pkg::HO_SET: begin
          if (lsel_r) begin
            love_head_nxt  = f_r;
            love_empty_nxt = 1'b0;
          end else begin
            hate_head_nxt  = f_r;
            hate_empty_nxt = 1'b0;
          end
        end
        lhfr_pkg::HO_UNLINK: begin
          // last frame leaves: list empties; head moves on when it leaves
          if (n_r == f_r) begin
            if (lsel_r) begin
              love_head_nxt  = '0;
              love_empty_nxt = 1'b1;
            end else begin
              hate_head_nxt  = '0;
              hate_empty_nxt = 1'b1;
            end
          end else if (head_sel == f_r) begin
            if (lsel_r) begin
              love_head_nxt = n_r;
            end else begin
              hate_head_nxt = n_r;
            end
          end
        end
        default: hate_head_nxt = hate_head_r;
      endcase

      if (mem_we) begin
        vld_nxt[f_r] = 1'b1;
      end

      if (ctl.fin) begin
        busy_nxt       = 1'b0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ctl.status;
        out_victim_nxt = ctl.victim ? lhfr_pkg::FRAME_W'(f_r) : '0;
      end else if (cond_true) begin
        upc_nxt = ctl.target;
      end else begin
        upc_nxt = upc_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      upc_r        <= lhfr_pkg::S_FIN_ABSENT;
      hate_head_r  <= '0;
      love_head_r  <= '0;
      hate_empty_r <= 1'b1;
      love_empty_r <= 1'b1;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      upc_r        <= upc_nxt;
      hate_head_r  <= hate_head_nxt;
      love_head_r  <= love_head_nxt;
      hate_empty_r <= hate_empty_nxt;
      love_empty_r <= love_empty_nxt;
      vld_r        <= vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    lsel_r       <= lsel_nxt;
    f_r          <= f_nxt;
    t_r          <= t_nxt;
    n_r          <= n_nxt;
    p_r          <= p_nxt;
    vld_q_r      <= vld_r[raddr];
    out_status_r <= out_status_nxt;
    out_victim_r <= out_victim_nxt;
  end

  lhfr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (raddr),
    .rdata (next_rd)
  );

  lhfr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (raddr),
    .rdata (prev_rd)
  );

  lhfr_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_mem_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (f_r),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (mem_rd)
  );

`include "love_hate_frame_replacement_assert.svh"

  `LHFR_ASSERT_IMP(a_upc_range, busy_r, upc_r <= lhfr_pkg::S_FIN_VICTIM, "step out of program")
  `LHFR_ASSERT_IMP(a_rise_from_fin, $rose(out_valid_r), $past(exec && ctl.fin),
                   "result raised outside a finishing step")
  `LHFR_ASSERT_IMP(a_victim_zero, out_valid_r && (out_status_r != lhfr_pkg::ST_OK),
                   out_victim_r == '0, "victim frame set on a failed request")
  `LHFR_ASSERT_NXT(a_head_set, exec && (ctl.ho == lhfr_pkg::HO_SET),
                   !($past(lsel_r) ? love_empty_r : hate_empty_r),
                   "list still empty after insert")

endmodule

// File: tb/lhfr_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the love/hate frame replacement testbench: a shadow copy of
// both circular frame lists and the queue of responses they predict.
// Depends on lhfr_pkg for field widths and operation, status and membership codes.
package lhfr_scoreboard_pkg;
  import lhfr_pkg::*;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic [1:0] status;
    frame_t     victim;
  } rsp_item_t;

  class replacement_scoreboard;
    frame_t      nxt[FRAME_SPAN];
    frame_t      prv[FRAME_SPAN];
    logic [1:0]  owner[FRAME_SPAN];
    frame_t      head[2];
    bit          empty[2];
    rsp_item_t   awaited[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < FRAME_SPAN; i++) begin
        nxt[i] = '0;
        prv[i] = '0;
        owner[i] = MEM_NONE;
      end
      head[0] = '0;
      head[1] = '0;
      empty[0] = 1'b1;
      empty[1] = 1'b1;
      errors = 0;
    endfunction

    function void push_head(int idx, frame_t f);
      frame_t h;
      frame_t t;
      if (empty[idx]) begin
        nxt[f] = f;
        prv[f] = f;
        empty[idx] = 1'b0;
      end else begin
        h = head[idx];
        t = prv[h];
        nxt[f] = h;
        prv[f] = t;
        nxt[t] = f;
        prv[h] = f;
      end
      head[idx] = f;
    endfunction

    function void unlink(int idx, frame_t f);
      frame_t n;
      frame_t p;
      n = nxt[f];
      p = prv[f];
      if (n == f) begin
        empty[idx] = 1'b1;
        head[idx] = '0;
      end else begin
        nxt[p] = n;
        prv[n] = p;
        if (head[idx] == f) head[idx] = n;
      end
      owner[f] = MEM_NONE;
    endfunction

    // Work out the response to an accepted request and queue it.
    function void note_request(logic [1:0] func, logic sel, frame_t f);
      rsp_item_t  r;
      int         idx;
      logic [1:0] code;
      frame_t     pick;
      idx = sel ? 1 : 0;
      code = sel ? MEM_LOVE : MEM_HATE;
      r.status = ST_ABSENT;
      r.victim = '0;
      case (func)
        FN_INSERT: begin
          if (owner[f] != MEM_NONE) begin
            r.status = ST_LISTED;
          end else begin
            push_head(idx, f);
            owner[f] = code;
            r.status = ST_OK;
          end
        end
        FN_REMOVE: begin
          if (owner[f] == code) begin
            unlink(idx, f);
            r.status = ST_OK;
          end
        end
        FN_LOOKUP: begin
          // hate list gives its newest frame, love list its oldest
          if (!empty[0]) begin
            pick = head[0];
            unlink(0, pick);
            r.victim = pick;
            r.status = ST_OK;
          end else if (!empty[1]) begin
            pick = prv[head[1]];
            unlink(1, pick);
            r.victim = pick;
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, frame_t victim);
      rsp_item_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected response status=%0d victim=%0d", $time, status, victim);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (status !== r.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, r.status, status);
        errors++;
      end
      if (victim !== r.victim) begin
        $display("%0t: victim_frame mismatch: expected %0d, got %0d",
                 $time, r.victim, victim);
        errors++;
      end
    endfunction

    // Find some listed frame, starting the scan at a random slot.
    function bit listed_frame(output frame_t f, output logic sel);
      int unsigned start;
      int unsigned k;
      start = $urandom_range(0, FRAME_SPAN - 1);
      f = '0;
      sel = 1'b0;
      for (int i = 0; i < FRAME_SPAN; i++) begin
        k = (start + i) % FRAME_SPAN;
        if (owner[k] != MEM_NONE) begin
          f = frame_t'(k);
          sel = (owner[k] == MEM_LOVE);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

endpackage

// File: tb/love_hate_frame_replacement_test.sv
`timescale 1ns / 100ps
// Top-level testbench of love_hate_frame_replacement: drives requests and takes
// responses with random gaps, checking each against lhfr_scoreboard_pkg.
// Depends on lhfr_pkg, lhfr_scoreboard_pkg, lhfr_if.sv and the block itself.
module love_hate_frame_replacement_test;
  import lhfr_pkg::*;
  import lhfr_scoreboard_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned BLOCK_ITEMS = 100;

  logic clk;
  logic rst_n;
  bit   quiet;
  int unsigned idle_cycles;

  replacement_scoreboard sb = new();

  lhfr_req_if in_req();
  lhfr_rsp_if out_rsp();

  love_hate_frame_replacement #(.NUM_FRAMES(64)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req),
    .out_rsp(out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic send_request(input logic [1:0] func, input logic sel, input frame_t f);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.func <= func;
    in_req.list_sel <= sel;
    in_req.frame_no <= f;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(func, sel, f);
  endtask

  // Hold off until every queued response has come back.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(input int unsigned mix);
    int unsigned ins_pct;
    int unsigned rem_pct;
    int unsigned roll;
    logic [1:0]  fn;
    logic        sel;
    frame_t      fr;
    frame_t      pf;
    logic        ps;
    case (mix)
      0: begin ins_pct = 60; rem_pct = 15; end
      1: begin ins_pct = 20; rem_pct = 35; end
      default: begin ins_pct = 40; rem_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    sel = 1'($urandom_range(0, 1));
    fr = frame_t'($urandom_range(0, FRAME_SPAN - 1));
    if (roll < ins_pct) begin
      fn = FN_INSERT;
    end else if (roll < ins_pct + rem_pct) begin
      fn = FN_REMOVE;
      if ($urandom_range(0, 3) != 0 && sb.listed_frame(pf, ps)) begin
        fr = pf;
        sel = ps;
      end
    end else if (roll < 96) begin
      fn = FN_LOOKUP;
    end else begin
      fn = FN_UNUSED;
    end
    send_request(fn, sel, fr);
  endtask

  // Response side: stall at random, then take and check one item.
  initial begin
    int unsigned stall;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = gap_len();
      if (stall != 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
      sb.check_response(out_rsp.status, out_rsp.victim_frame);
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    quiet = 1'b0;
    in_req.valid <= 1'b0;
    in_req.func <= FN_INSERT;
    in_req.list_sel <= 1'b0;
    in_req.frame_no <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty lists, rejections, both lookup sources, head and middle removal
    send_request(FN_LOOKUP, 1'b0, 6'd0);
    send_request(FN_REMOVE, 1'b0, 6'd5);
    send_request(FN_INSERT, 1'b0, 6'd0);
    send_request(FN_INSERT, 1'b0, 6'd63);
    send_request(FN_INSERT, 1'b1, 6'd0);
    send_request(FN_INSERT, 1'b0, 6'd63);
    send_request(FN_REMOVE, 1'b1, 6'd63);
    send_request(FN_LOOKUP, 1'b1, 6'd63);
    send_request(FN_INSERT, 1'b1, 6'd10);
    send_request(FN_INSERT, 1'b1, 6'd20);
    send_request(FN_INSERT, 1'b1, 6'd30);
    send_request(FN_INSERT, 1'b1, 6'd42);
    send_request(FN_REMOVE, 1'b1, 6'd30);
    send_request(FN_REMOVE, 1'b1, 6'd42);
    send_request(FN_LOOKUP, 1'b0, 6'd0);
    send_request(FN_LOOKUP, 1'b1, 6'd0);
    send_request(FN_LOOKUP, 1'b0, 6'd0);
    send_request(FN_LOOKUP, 1'b0, 6'd0);
    send_request(FN_UNUSED, 1'b1, 6'd63);
    send_request(FN_INSERT, 1'b1, 6'd21);
    send_request(FN_REMOVE, 1'b1, 6'd21);
    send_request(FN_INSERT, 1'b0, 6'd42);
    send_request(FN_REMOVE, 1'b0, 6'd42);
    drain();

    // random: alternate filling, emptying and mixed stretches
    for (int unsigned blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS + 1; blk++) begin
      quiet = (blk % 4 == 3);
      if (blk == 9) drain();
      for (int unsigned i = 0; i < BLOCK_ITEMS && blk * BLOCK_ITEMS + i < RANDOM_ITEMS; i++)
        random_request(blk % 3);
    end
    quiet = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
